### design/swm_pkg.sv
// shared types and constants of the sliding window median filter
// no dependencies
package swm_pkg;

    localparam int DEF_MAX_WINDOW   = 64;
    localparam int DEF_SAMPLE_WIDTH = 32;
    localparam int PORT_BITS        = 32;
    localparam int CFG_BITS         = 7;

    // per-cell control for one update of the sorted chain
    typedef struct packed {
        logic load;
        logic shifted;
        logic in_window;
    } cell_ctl_t;

    // status of the output stage seen by the top level
    typedef struct packed {
        logic can_take;
    } out_stat_t;

endpackage

### design/swm_cell.sv
// one cell of the sorted chain: holds one sample and its age
// depends on swm_pkg
module swm_cell #(
    parameter int SW = swm_pkg::DEF_SAMPLE_WIDTH,
    parameter int AW = 6
) (
    input  logic                    aclk,
    input  swm_pkg::cell_ctl_t      ctl,
    input  logic signed [SW-1:0]    sample,
    input  logic signed [SW-1:0]    up_value,
    input  logic [AW-1:0]           up_age,
    input  logic                    up_le,
    input  logic signed [SW-1:0]    dn_bval,
    input  logic [AW-1:0]           dn_bage,
    input  logic                    dn_leb,
    output logic signed [SW-1:0]    value,
    output logic [AW-1:0]           age,
    output logic                    le,
    output logic signed [SW-1:0]    bval,
    output logic [AW-1:0]           bage,
    output logic                    leb
);
    import swm_pkg::*;

    logic signed [SW-1:0] value_reg, value_next;
    logic [AW-1:0]        age_reg, age_next;

    assign value = value_reg;
    assign age   = age_reg;
    assign le    = (value_reg <= sample);

    // window after the eviction: take the upper neighbor above the removed entry
    assign bval = ctl.shifted ? up_value : value_reg;
    assign bage = ctl.shifted ? up_age : age_reg;
    assign leb  = ctl.in_window && (ctl.shifted ? up_le : le);

    always_comb begin
        if (leb) begin
            value_next = bval;
            age_next   = bage + AW'(1);
        end else if (dn_leb) begin
            value_next = sample;
            age_next   = '0;
        end else begin
            value_next = dn_bval;
            age_next   = dn_bage + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

### design/swm_out.sv
// output stage: holds the two middle values, averages them, output register
// depends on swm_pkg
module swm_out #(
    parameter int SW = swm_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  logic signed [SW-1:0]              lo,
    input  logic signed [SW-1:0]              hi,
    output swm_pkg::out_stat_t                stat,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [swm_pkg::PORT_BITS-1:0] m_median
);
    import swm_pkg::*;

    logic                 mid_valid_reg, mid_valid_next;
    logic signed [SW-1:0] lo_reg, hi_reg;
    logic                 m_valid_reg, m_valid_next;
    logic signed [PORT_BITS-1:0] m_median_reg;
    logic signed [SW:0]   sum;
    logic signed [SW:0]   half;
    logic                 out_free;

    assign out_free      = !m_valid_reg || m_ready;
    assign stat.can_take = !mid_valid_reg || out_free;

    // mean rounded toward zero: bump negative sums before the shift
    assign sum  = (SW+1)'(lo_reg) + (SW+1)'(hi_reg);
    assign half = (sum + (SW+1)'(sum[SW])) >>> 1;

    always_comb begin
        mid_valid_next = mid_valid_reg;
        if (load) begin
            mid_valid_next = 1'b1;
        end else if (out_free) begin
            mid_valid_next = 1'b0;
        end
        m_valid_next = out_free ? mid_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            mid_valid_reg <= mid_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            lo_reg <= lo;
            hi_reg <= hi;
        end
        if (out_free && mid_valid_reg) begin
            m_median_reg <= PORT_BITS'(signed'(half[SW-1:0]));
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_median = m_median_reg;

endmodule

### design/sliding_window_median_top.sv
// sliding window median filter, top level
// depends on swm_pkg, swm_cell, swm_out
//
// input channel s_*: one signed sample per request, s_first_sample = 1
// empties the window before the sample enters. result channel m_*: one
// median per request once the window holds window_size samples, including
// the request that first fills it. an even window gives the mean of the two
// middle values, truncated toward zero.
// config channel cfg_*: writes window_size (0 reads as 1, values above
// MAX_WINDOW saturate) and empties the window; always ready, write only
// while no request is in flight.
// throughput: one request per cycle unless m_* stalls. the sorted chain
// updates in the accept cycle, then the middle values are picked into the
// middle-value stage and the median lands in the output register that
// drives m_valid. a stalled receiver first fills the middle-value stage,
// then the chain stops taking requests until the output register drains.
// reset: window empty, window_size = 1, both channels idle.
module sliding_window_median_top #(
    parameter int MAX_WINDOW   = swm_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [swm_pkg::PORT_BITS-1:0]   s_sample,
    input  logic                                   s_first_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [swm_pkg::PORT_BITS-1:0]   m_median,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [swm_pkg::CFG_BITS-1:0]           cfg_wdata
);
    import swm_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int KW = $clog2(MAX_WINDOW + 1);          // holds 0..MAX_WINDOW
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    // window size and fill level
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] fill_reg, fill_next;
    logic          pend_reg, pend_next;   // updated chain waits for middle pick

    logic          accept;
    logic [KW-1:0] fill_eff;
    logic          full;
    logic [KW-1:0] keep_cnt;              // entries left after the eviction
    logic          emit;
    logic signed [SW-1:0] sample_in;
    out_stat_t     stat;
    logic          pick;

    // chain wiring
    cell_ctl_t             ctl      [MAX_WINDOW];
    logic signed [SW-1:0]  cval     [MAX_WINDOW];
    logic [AW-1:0]         cage     [MAX_WINDOW];
    logic                  cle      [MAX_WINDOW];
    logic signed [SW-1:0]  cbval    [MAX_WINDOW];
    logic [AW-1:0]         cbage    [MAX_WINDOW];
    logic                  cleb     [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] oldest;

    // middle selection
    logic [KW-1:0]        hi_idx, lo_idx;
    logic signed [SW-1:0] lo_sel, hi_sel;

    assign sample_in = s_sample[SW-1:0];
    assign cfg_ready = 1'b1;

    // the chain may move when no pick is pending or the pending pick can leave this cycle
    assign s_ready = !pend_reg || stat.can_take;
    assign accept  = s_valid && s_ready;
    assign pick    = pend_reg && stat.can_take;

    assign fill_eff = s_first_sample ? '0 : fill_reg;
    assign full     = (fill_eff >= k_reg);
    assign keep_cnt = full ? (k_reg - KW'(1)) : fill_eff;
    assign emit     = full || ((fill_eff + KW'(1)) == k_reg);

    always_comb begin
        k_next    = k_reg;
        fill_next = fill_reg;
        pend_next = pend_reg;
        if (cfg_valid) begin
            // saturate the written size to 1..MAX_WINDOW
            if (cfg_wdata == '0) begin
                k_next = KW'(1);
            end else if (32'(cfg_wdata) > 32'(MAX_WINDOW)) begin
                k_next = KW'(MAX_WINDOW);
            end else begin
                k_next = KW'(cfg_wdata);
            end
            fill_next = '0;
        end else if (accept) begin
            fill_next = full ? k_reg : fill_eff + KW'(1);
        end
        if (accept) begin
            pend_next = emit;
        end else if (pick) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg    <= KW'(1);
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            k_reg    <= k_next;
            fill_reg <= fill_next;
            pend_reg <= pend_next;
        end
    end

    // sorted chain: ascending from cell 0, the oldest entry leaves when full
    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
            logic signed [SW-1:0] up_v;
            logic [AW-1:0]        up_a;
            logic                 up_l;
            logic signed [SW-1:0] dn_v;
            logic [AW-1:0]        dn_a;
            logic                 dn_l;

            // entry with age k-1 is the one that leaves a full window
            assign oldest[gi] = full && (KW'(gi) < fill_eff)
                                && (KW'(cage[gi]) == (k_reg - KW'(1)));

            assign ctl[gi].load      = accept;
            assign ctl[gi].shifted   = |oldest[gi:0];
            assign ctl[gi].in_window = (KW'(gi) < keep_cnt);

            if (gi == MAX_WINDOW - 1) begin : g_top
                assign up_v = '0;
                assign up_a = '0;
                assign up_l = 1'b0;
            end else begin : g_mid
                assign up_v = cval[gi+1];
                assign up_a = cage[gi+1];
                assign up_l = cle[gi+1];
            end

            if (gi == 0) begin : g_bot
                // nothing below the first cell: new sample goes here at most
                assign dn_v = '0;
                assign dn_a = '0;
                assign dn_l = 1'b1;
            end else begin : g_low
                assign dn_v = cbval[gi-1];
                assign dn_a = cbage[gi-1];
                assign dn_l = cleb[gi-1];
            end

            swm_cell #(
                .SW(SW),
                .AW(AW)
            ) u_cell (
                .aclk     (aclk),
                .ctl      (ctl[gi]),
                .sample   (sample_in),
                .up_value (up_v),
                .up_age   (up_a),
                .up_le    (up_l),
                .dn_bval  (dn_v),
                .dn_bage  (dn_a),
                .dn_leb   (dn_l),
                .value    (cval[gi]),
                .age      (cage[gi]),
                .le       (cle[gi]),
                .bval     (cbval[gi]),
                .bage     (cbage[gi]),
                .leb      (cleb[gi])
            );
        end
    endgenerate

    // middle entries: same cell twice for an odd window
    assign hi_idx = k_reg >> 1;
    assign lo_idx = k_reg[0] ? hi_idx : hi_idx - KW'(1);

    always_comb begin
        lo_sel = '0;
        hi_sel = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            lo_sel = lo_sel | (cval[i] & {SW{KW'(i) == lo_idx}});
            hi_sel = hi_sel | (cval[i] & {SW{KW'(i) == hi_idx}});
        end
    end

    swm_out #(
        .SW(SW)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (pick),
        .lo       (lo_sel),
        .hi       (hi_sel),
        .stat     (stat),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_median (m_median)
    );

endmodule

### design/swm_checker.sv
// port-level checks of the sliding window median filter, bound to the top
// depends on sliding_window_median_top
module swm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_median
);

    // a stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_median))
        else $error("stalled median changed");

    // reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // with the output register empty nothing in the pipe can stall
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a fresh result follows an accepted request
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 3))
        else $error("result without matching request");

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_median (m_median)
);
